// ----- rtl/core/nfcrs_pkg.sv -----
// Package for the nearest free cell ring search core.
// Transfer payload types, sequencer states and inter-module control structs.
// No dependencies.
`timescale 1ns / 1ps

package nfcrs_pkg;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic       cell_free;
    } req_t;

    typedef struct packed {
        logic [3:0] drop_x;
        logic [3:0] drop_y;
        logic       found_free;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic advance;
    } walk_ctrl_t;

    typedef struct packed {
        logic clearing;
    } map_stat_t;

endpackage

// ----- rtl/core/nfcrs_ring_walker.sv -----
// Ring offset sequencer: steps (dx, dy) over the perimeter of square rings.
// Centre cell first, then radius 1 up to MAP_WIDTH - 1. Uses nfcrs_pkg.
`timescale 1ns / 1ps

module nfcrs_ring_walker #(
    parameter int MAP_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nfcrs_pkg::walk_ctrl_t          ctrl,
    output logic signed [$clog2(MAP_WIDTH):0] dx,
    output logic signed [$clog2(MAP_WIDTH):0] dy,
    output logic                           last
);

    localparam int RB = $clog2(MAP_WIDTH);
    localparam int OW = RB + 1;
    localparam logic [RB-1:0] R_LAST = RB'(MAP_WIDTH - 1);

    logic [RB-1:0]        r_reg, r_next;
    logic signed [OW-1:0] dx_reg, dx_next;
    logic signed [OW-1:0] dy_reg, dy_next;
    logic [RB-1:0]        r_inc;
    logic signed [OW-1:0] r_s, r_inc_s;
    logic                 row_end, ring_end, edge_row;

    assign r_inc    = r_reg + 1'b1;
    assign r_s      = $signed({1'b0, r_reg});
    assign r_inc_s  = $signed({1'b0, r_inc});
    assign row_end  = (dx_reg == r_s);
    assign ring_end = row_end && (dy_reg == r_s);
    assign edge_row = (dy_reg == r_s) || (dy_reg == -r_s);

    assign dx   = dx_reg;
    assign dy   = dy_reg;
    assign last = ring_end && (r_reg == R_LAST);

    always_comb
    begin
        r_next  = r_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        if (ctrl.start)
        begin
            r_next  = '0;
            dx_next = '0;
            dy_next = '0;
        end
        else if (ctrl.advance)
        begin
            priority if (ring_end)
            begin
                if (!last)
                begin
                    r_next  = r_inc;
                    dx_next = -r_inc_s;
                    dy_next = -r_inc_s;
                end
            end
            else if (row_end)
            begin
                dy_next = dy_reg + 1'b1;
                dx_next = -r_s;
            end
            else if (edge_row)
            begin
                dx_next = dx_reg + 1'b1;
            end
            else
            begin
                // side rows only hold the two end cells
                dx_next = r_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg  <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
        end
        else
        begin
            r_reg  <= r_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

endmodule

// ----- rtl/core/nfcrs_free_map.sv -----
// One-bit free map memory: one write port, one registered read port.
// Clears itself to blocked after reset, one entry per cycle. Uses nfcrs_pkg.
`timescale 1ns / 1ps

module nfcrs_free_map #(
    parameter int ADDR_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic                  wr_bit,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic                  rd_bit,
    output nfcrs_pkg::map_stat_t  stat
);

    localparam int DEPTH = 1 << ADDR_W;

    logic                mem [DEPTH];
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clearing_reg, clearing_next;
    logic                rd_bit_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_bit;

    assign stat.clearing = clearing_reg;
    assign rd_bit        = rd_bit_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clearing_next = 1'b0;
            end
        end
        mem_we   = clearing_reg || wr_en;
        mem_addr = clearing_reg ? clr_cnt_reg : wr_addr;
        mem_bit  = clearing_reg ? 1'b0 : wr_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_bit;
        end
        rd_bit_reg <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/nearest_free_cell_ring_search_core.sv -----
// Top level of the nearest free cell ring search core.
// Depends on nfcrs_pkg, nfcrs_ring_walker and nfcrs_free_map.
`timescale 1ns / 1ps
//
// Usage:
//   req channel (req_valid / req_stall / req) carries write and search items.
//   A write (mode 0) sets one cell's free bit; it gives no result and the
//   core is ready again the next cycle. Writes outside the grid are dropped.
//   A search (mode 1) gives one transfer on the rsp channel: the nearest free
//   cell in ring order, or the start cell with found_free low.
// Search:
//   A search visits N cells, the start cell included, at most
//   1 + 4*W*(W-1) for W = MAP_WIDTH (961 on a 16 by 16 grid), with one map
//   read per cycle. req_stall stays high while a search runs.
// Reset:
//   After rst_n the map is cleared to blocked, one entry per cycle, over all
//   2^(clog2(MAP_WIDTH) + clog2(MAP_HEIGHT)) entries (256 by default); req_stall
//   is high meanwhile.
// Stall:
//   The result waits in an output register while rsp_stall is high; writes
//   and a new search are still taken, and a search that finishes behind a
//   waiting result holds until the register frees.

module nearest_free_cell_ring_search_core #(
    parameter int MAP_WIDTH  = 16,
    parameter int MAP_HEIGHT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  nfcrs_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output nfcrs_pkg::rsp_t   rsp
);

    localparam int XB     = $clog2(MAP_WIDTH);
    localparam int YB     = $clog2(MAP_HEIGHT);
    localparam int ADDR_W = XB + YB;
    localparam int OW     = XB + 1;
    localparam int CW     = $clog2(MAP_WIDTH + 16) + 1;
    localparam int HW     = $clog2(MAP_HEIGHT + 16) + 1;
    localparam int KW     = (CW > HW) ? CW : HW;
    localparam logic signed [KW-1:0] W_S = KW'(MAP_WIDTH);
    localparam logic signed [KW-1:0] H_S = KW'(MAP_HEIGHT);

    nfcrs_pkg::state_t     state_reg, state_next;
    nfcrs_pkg::walk_ctrl_t walk_ctrl;
    nfcrs_pkg::map_stat_t  map_stat;
    nfcrs_pkg::rsp_t       res_reg, res_next;
    nfcrs_pkg::rsp_t       rsp_reg;

    logic                  accept, is_search;
    logic                  issue, load, hit, scan_end;
    logic                  issue_on_reg, issue_on_next;
    logic                  cand_valid_reg, cand_inb_reg, cand_last_reg;
    logic [3:0]            cand_x_reg, cand_y_reg;
    logic [3:0]            sx_reg, sy_reg;
    logic                  rsp_valid_reg;

    logic signed [OW-1:0]  walk_dx, walk_dy;
    logic                  walk_last;
    logic signed [KW-1:0]  pos_x, pos_y;
    logic                  pos_inb;
    logic signed [KW-1:0]  wr_x, wr_y;
    logic                  wr_inb, wr_en, rd_bit;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;

    nfcrs_ring_walker #(
        .MAP_WIDTH (MAP_WIDTH)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (walk_ctrl),
        .dx    (walk_dx),
        .dy    (walk_dy),
        .last  (walk_last)
    );

    nfcrs_free_map #(
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_bit  (req.cell_free),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit),
        .stat    (map_stat)
    );

    // search coordinate adder (writes address the map separately)
    assign pos_x   = $signed(KW'(sx_reg)) + KW'(walk_dx);
    assign pos_y   = $signed(KW'(sy_reg)) + KW'(walk_dy);
    assign pos_inb = (pos_x >= 0) && (pos_x < W_S) && (pos_y >= 0) && (pos_y < H_S);
    assign rd_addr = {pos_y[YB-1:0], pos_x[XB-1:0]};

    assign wr_x    = $signed(KW'(req.cell_x));
    assign wr_y    = $signed(KW'(req.cell_y));
    assign wr_inb  = (wr_x < W_S) && (wr_y < H_S);
    assign wr_addr = {wr_y[YB-1:0], wr_x[XB-1:0]};

    assign is_search = (req.mode == nfcrs_pkg::MODE_SEARCH);
    assign accept    = req_valid && !req_stall;
    assign hit       = cand_valid_reg && cand_inb_reg && rd_bit;
    assign scan_end  = hit || (cand_valid_reg && cand_last_reg);

    assign req_stall = (state_reg != nfcrs_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfcrs_pkg::ST_CLEAR:
            begin
                if (!map_stat.clearing)
                begin
                    state_next = nfcrs_pkg::ST_IDLE;
                end
            end
            nfcrs_pkg::ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = nfcrs_pkg::ST_SCAN;
                end
            end
            nfcrs_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = nfcrs_pkg::ST_FIN;
                end
            end
            nfcrs_pkg::ST_FIN:
            begin
                if (load)
                begin
                    state_next = nfcrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfcrs_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        walk_ctrl.start   = accept && is_search;
        issue             = (state_reg == nfcrs_pkg::ST_SCAN) && issue_on_reg;
        walk_ctrl.advance = issue;
        wr_en             = accept && !is_search && wr_inb;
        load              = (state_reg == nfcrs_pkg::ST_FIN) && (!rsp_valid_reg || !rsp_stall);

        issue_on_next = issue_on_reg;
        if (walk_ctrl.start)
        begin
            issue_on_next = 1'b1;
        end
        else if (issue && walk_last)
        begin
            issue_on_next = 1'b0;
        end

        res_next = res_reg;
        if ((state_reg == nfcrs_pkg::ST_SCAN) && scan_end)
        begin
            if (hit)
            begin
                res_next.drop_x     = cand_x_reg;
                res_next.drop_y     = cand_y_reg;
                res_next.found_free = 1'b1;
            end
            else
            begin
                res_next.drop_x     = sx_reg;
                res_next.drop_y     = sy_reg;
                res_next.found_free = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nfcrs_pkg::ST_CLEAR;
            issue_on_reg   <= 1'b0;
            cand_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_on_reg   <= issue_on_next;
            cand_valid_reg <= issue;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_ctrl.start)
        begin
            sx_reg <= req.cell_x;
            sy_reg <= req.cell_y;
        end
        if (issue)
        begin
            cand_x_reg    <= pos_x[3:0];
            cand_y_reg    <= pos_y[3:0];
            cand_inb_reg  <= pos_inb;
            cand_last_reg <= walk_last;
        end
        res_reg <= res_next;
        if (load)
        begin
            rsp_reg <= res_reg;
        end
    end

endmodule

// ----- rtl/core/nfcrs_checker.sv -----
// Port-level checker for the nearest free cell ring search core.
// Bound to nearest_free_cell_ring_search_core; uses nfcrs_pkg.
`timescale 1ns / 1ps

module nfcrs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input nfcrs_pkg::req_t  req,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input nfcrs_pkg::rsp_t  rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("result changed or dropped while stalled");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.mode == nfcrs_pkg::MODE_SEARCH) |=> req_stall)
        else $error("search transfer not followed by busy");

    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.mode == nfcrs_pkg::MODE_WRITE) |=> !req_stall)
        else $error("write transfer left core busy");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> req_stall)
        else $error("request taken during map clear");

endmodule

bind nearest_free_cell_ring_search_core nfcrs_checker u_nfcrs_checker (.*);
